### hdl/lrc_parity_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// LRC parity encoder assertion macros
// Concurrent assertion wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef LRC_PARITY_ENCODER_UNIT_MACROS_SVH
`define LRC_PARITY_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define LRCPE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lrcpe assertion failed");

// checked at every rising edge, reset included
`define LRCPE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lrcpe assertion failed");

`else

`define LRCPE_ASSERT(label, clk, rstn, prop)
`define LRCPE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### hdl/lrcpe_pkg.sv
// ----------------------------------------------------------------------------
// LRC parity encoder package
// Field widths and GF(2^8) arithmetic, polynomial 0x11D.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrcpe_pkg;

    localparam int BLK_W   = 4;
    localparam int SYM_W   = 8;
    localparam int PIDX_W  = 2;
    localparam int BLK_CNT = 2 ** BLK_W;

    localparam logic [SYM_W:0] GF_POLY = 9'h11D;

    typedef logic [BLK_W-1:0]  blk_t;
    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [PIDX_W-1:0] pidx_t;

    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        logic [SYM_W:0] x;
        sym_t           acc;
        acc = '0;
        x   = {1'b0, a};
        for (int i = 0; i < SYM_W; i++) begin
            if (b[i]) begin
                acc = acc ^ x[SYM_W-1:0];
            end
            x = {x[SYM_W-1:0], 1'b0};
            if (x[SYM_W]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

### hdl/lrc_parity_encoder_unit.sv
// ----------------------------------------------------------------------------
// LRC parity encoder unit
// Local and global parity of one stripe column over GF(2^8).
//
//   Channel  Ports                                   Moves
//   s_       block_index, symbol                     one data symbol per transfer
//   m_       parity_index, parity_symbol, last_of_run one parity per transfer
//
// One symbol a cycle unless stalled: input register, table driven bit-matrix
// XOR, accumulators. The last block of a column copies all parities into a
// shift register that drains one parity a cycle while m_ready is high and the
// next column loads. A last block stalls only while the previous column is
// still draining. Reset clears accumulators and control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lrc_parity_encoder_unit_macros.svh"

module lrc_parity_encoder_unit #(
    parameter int DATA_BLOCKS     = 12,
    parameter int LOCAL_GROUPS    = 2,
    parameter int GROUP_SIZE      = 6,
    parameter int GLOBAL_PARITIES = 2
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  lrcpe_pkg::blk_t s_block_index,
    input  wire  lrcpe_pkg::sym_t s_symbol,
    output logic                  m_valid,
    input  wire                   m_ready,
    output lrcpe_pkg::pidx_t      m_parity_index,
    output lrcpe_pkg::sym_t       m_parity_symbol,
    output logic                  m_last_of_run
);

    import lrcpe_pkg::*;

    localparam int NUM_PAR  = LOCAL_GROUPS + GLOBAL_PARITIES;
    localparam int CNT_W    = $clog2(NUM_PAR);
    localparam int CMP_W    = 6;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_PAR - 1);
    localparam logic [CMP_W-1:0] BLK_END  = CMP_W'(DATA_BLOCKS);
    localparam logic [CMP_W-1:0] BLK_LAST = CMP_W'(DATA_BLOCKS - 1);

    typedef logic [BLK_CNT-1:0][GLOBAL_PARITIES-1:0][SYM_W-1:0][SYM_W-1:0] row_tbl_t;
    typedef logic [BLK_CNT-1:0][BLK_W-1:0] grp_tbl_t;

    // rows of the transposed bit matrix per block and global parity
    function automatic row_tbl_t build_row_tbl();
        row_tbl_t tbl;
        int       grp;
        int       pos;
        int       shift;
        sym_t     base;
        sym_t     c;
        sym_t     m;
        tbl = '0;
        for (int b = 0; b < BLK_CNT; b++) begin
            grp   = b / GROUP_SIZE;
            pos   = b % GROUP_SIZE;
            shift = grp * 4;
            if (shift > 16) begin
                shift = 16;
            end
            base = sym_t'(((pos + 1) << shift) & 255);
            c    = base;
            for (int t = 0; t < GLOBAL_PARITIES; t++) begin
                m = c;
                for (int x = 0; x < SYM_W; x++) begin
                    tbl[b][t][x] = m;
                    m = gf_mul(m, sym_t'(2));
                end
                c = gf_mul(c, base);
            end
        end
        return tbl;
    endfunction

    // group number of each block
    function automatic grp_tbl_t build_grp_tbl();
        grp_tbl_t tbl;
        tbl = '0;
        for (int b = 0; b < BLK_CNT; b++) begin
            tbl[b] = BLK_W'(b / GROUP_SIZE);
        end
        return tbl;
    endfunction

    localparam row_tbl_t ROW_TBL = build_row_tbl();
    localparam grp_tbl_t GRP_TBL = build_grp_tbl();

    logic             in_valid_reg;
    blk_t             in_blk_reg;
    sym_t             in_sym_reg;
    logic             in_range;
    logic             is_first;
    logic             is_last;
    logic             out_free;
    logic             consume;
    logic             snap_load;
    logic             m_xfer;
    blk_t             grp;
    sym_t             contrib   [NUM_PAR];
    sym_t             acc_reg   [NUM_PAR];
    sym_t             acc_next  [NUM_PAR];
    sym_t             snap_reg  [NUM_PAR];
    logic             out_busy_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    assign in_range  = CMP_W'(in_blk_reg) < BLK_END;
    assign is_last   = CMP_W'(in_blk_reg) == BLK_LAST;
    assign is_first  = in_blk_reg == '0;
    assign m_xfer    = out_busy_reg && m_ready;
    assign out_free  = !out_busy_reg || (m_ready && out_cnt_reg == LAST_CNT);
    assign consume   = in_valid_reg && (!is_last || out_free);
    assign snap_load = consume && is_last;
    assign s_ready   = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_blk_reg <= s_block_index;
            in_sym_reg <= s_symbol;
        end
    end

    assign grp = GRP_TBL[in_blk_reg];

    always_comb begin
        for (int i = 0; i < NUM_PAR; i++) begin
            contrib[i] = '0;
        end
        for (int i = 0; i < LOCAL_GROUPS; i++) begin
            if (grp == BLK_W'(i)) begin
                contrib[i] = in_sym_reg;
            end
        end
        for (int t = 0; t < GLOBAL_PARITIES; t++) begin
            for (int x = 0; x < SYM_W; x++) begin
                contrib[LOCAL_GROUPS+t][x] = ^(ROW_TBL[in_blk_reg][t][x] & in_sym_reg);
            end
        end
        for (int i = 0; i < NUM_PAR; i++) begin
            acc_next[i] = is_first ? contrib[i] : (acc_reg[i] ^ contrib[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PAR; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (consume && in_range) begin
            for (int i = 0; i < NUM_PAR; i++) begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_busy_reg <= 1'b0;
            out_cnt_reg  <= '0;
        end else if (snap_load) begin
            out_busy_reg <= 1'b1;
            out_cnt_reg  <= '0;
        end else if (m_xfer) begin
            if (out_cnt_reg == LAST_CNT) begin
                out_busy_reg <= 1'b0;
            end else begin
                out_cnt_reg <= out_cnt_reg + CNT_W'(1);
            end
        end
    end

    // parity shift register, head is the parity on offer
    always_ff @(posedge aclk) begin
        if (snap_load) begin
            for (int i = 0; i < NUM_PAR; i++) begin
                snap_reg[i] <= acc_next[i];
            end
        end else if (m_xfer) begin
            for (int i = 0; i < NUM_PAR - 1; i++) begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

    assign m_valid         = out_busy_reg;
    assign m_parity_index  = PIDX_W'(out_cnt_reg);
    assign m_parity_symbol = snap_reg[0];
    assign m_last_of_run   = out_cnt_reg == LAST_CNT;

    `LRCPE_ASSERT(a_load_when_free, aclk, aresetn, snap_load |-> out_free)
    `LRCPE_ASSERT(a_load_starts_run, aclk, aresetn, snap_load |=> (m_valid && out_cnt_reg == '0))
    `LRCPE_ASSERT(a_last_ends_run, aclk, aresetn, (m_xfer && m_last_of_run && !snap_load) |=> !m_valid)
    `LRCPE_ASSERT_ALWAYS(a_idle_in_reset, aclk, !aresetn |=> (!m_valid && !in_valid_reg))

endmodule

`default_nettype wire
